/* design/matrix_row_column_sorter_core_defines.svh */
// assertion helpers used by the sorter controller
`ifndef MATRIX_ROW_COLUMN_SORTER_CORE_DEFINES_SVH
`define MATRIX_ROW_COLUMN_SORTER_CORE_DEFINES_SVH

// same-cycle implication, disabled during reset
`define MRCS_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled during reset
`define MRCS_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* design/mrcs_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package mrcs_pkg;

    localparam int DATA_W = 32;

    // register indexes on the configuration port
    localparam logic [1:0] REG_SORT_DIRECTION = 2'd0;
    localparam logic [1:0] REG_NUM_ROWS       = 2'd1;
    localparam logic [1:0] REG_NUM_COLS       = 2'd2;

    typedef struct packed {
        logic mem_wr_in;
        logic fetch_rd;
        logic wb_wr;
        logic emit_rd;
        logic sort_en;
        logic sort_odd;
        logic line_first;
        logic line_next;
        logic line_rewind;
        logic addr_clr;
    } t_dp_cmd;

    typedef struct packed {
        logic out_free;
    } t_dp_status;

endpackage

`default_nettype wire

/* design/matrix_row_column_sorter_core.sv */
`timescale 1ns / 1ps
`default_nettype none
// Matrix row/column sorter. Elements of a signed 32-bit matrix arrive in row-major order,
// one per request, until num_rows x num_cols have been taken (a dimension of 0 acts as 1,
// any value above the maximum acts as the maximum). The block then sorts every column
// (sort_direction 0) or every row (sort_direction 1) in ascending signed order and sends
// the whole matrix back in row-major order with the row and column of each element and
// tlast on the final element. Input is ready throughout loading. Each line is then
// read from the single-port element store into a line buffer, sorted by odd-even
// transposition and written back; emission advances while the output register is free
// or the sink is ready. Loading, fetching, write-back and emission all use the one store
// port. Input is not taken while sorting or emitting; it is taken again while the last
// result still waits in the output register.
// Registers sit at byte addresses 0 (sort_direction), 4 (num_rows) and 8 (num_cols).

module matrix_row_column_sorter_core #(
    parameter int MAX_ROWS = 8,
    parameter int MAX_COLS = 8
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [3:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [31:0] s_axis_tdata,  // [31:0] elem_value
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [39:0]      m_axis_tdata,  // [31:0] out_value, [34:32] out_row, [37:35] out_col
    output logic             m_axis_tlast
);
    import mrcs_pkg::*;

    localparam int LANES  = (MAX_ROWS > MAX_COLS) ? MAX_ROWS : MAX_COLS;
    localparam int DIM_W  = $clog2(LANES + 1);
    localparam int LANE_W = (LANES > 1) ? $clog2(LANES) : 1;
    localparam int CW     = (DIM_W > 4) ? DIM_W : 4;

    logic             r_dir;
    logic [3:0]       r_rows, r_cols;
    logic [1:0]       w_reg_idx;
    logic             w_wr;
    logic [CW-1:0]    w_rows_x, w_cols_x;
    logic [DIM_W-1:0] w_rows, w_cols;

    t_dp_cmd          w_cmd;
    t_dp_status       w_status;
    logic [LANE_W-1:0] w_idx;
    logic [DIM_W-1:0] w_len, w_row, w_col;
    logic             w_last;
    logic signed [31:0] w_out_value;
    logic [2:0]       w_out_row, w_out_col;

    assign w_reg_idx = paddr[3:2];
    assign w_wr      = psel && penable && pwrite;
    assign pready    = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dir  <= 1'b0;
            r_rows <= 4'd8;
            r_cols <= 4'd5;
        end else if (w_wr) begin
            unique case (w_reg_idx)
                REG_SORT_DIRECTION: r_dir  <= pwdata[0];
                REG_NUM_ROWS:       r_rows <= pwdata[3:0];
                REG_NUM_COLS:       r_cols <= pwdata[3:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (w_reg_idx)
            REG_SORT_DIRECTION: prdata = {31'd0, r_dir};
            REG_NUM_ROWS:       prdata = {28'd0, r_rows};
            REG_NUM_COLS:       prdata = {28'd0, r_cols};
            default:            prdata = '0;
        endcase
    end

    // dimension clamp
    always_comb begin
        w_rows_x = CW'(r_rows);
        w_cols_x = CW'(r_cols);
        if (w_rows_x == '0) begin
            w_rows_x = CW'(1);
        end else if (w_rows_x > CW'(MAX_ROWS)) begin
            w_rows_x = CW'(MAX_ROWS);
        end
        if (w_cols_x == '0) begin
            w_cols_x = CW'(1);
        end else if (w_cols_x > CW'(MAX_COLS)) begin
            w_cols_x = CW'(MAX_COLS);
        end
    end

    assign w_rows = DIM_W'(w_rows_x);
    assign w_cols = DIM_W'(w_cols_x);

    mrcs_ctrl #(
        .MAX_ROWS (MAX_ROWS),
        .MAX_COLS (MAX_COLS)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_dir      (r_dir),
        .i_rows     (w_rows),
        .i_cols     (w_cols),
        .i_s_tvalid (s_axis_tvalid),
        .o_s_tready (s_axis_tready),
        .o_cmd      (w_cmd),
        .i_status   (w_status),
        .o_idx      (w_idx),
        .o_len      (w_len),
        .o_row      (w_row),
        .o_col      (w_col),
        .o_last     (w_last)
    );

    mrcs_dp #(
        .MAX_ROWS (MAX_ROWS),
        .MAX_COLS (MAX_COLS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_dir       (r_dir),
        .i_cols      (w_cols),
        .i_cmd       (w_cmd),
        .o_status    (w_status),
        .i_idx       (w_idx),
        .i_len       (w_len),
        .i_row       (w_row),
        .i_col       (w_col),
        .i_last      (w_last),
        .i_in_value  (s_axis_tdata),
        .o_out_value (w_out_value),
        .o_out_row   (w_out_row),
        .o_out_col   (w_out_col),
        .o_out_last  (m_axis_tlast),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready)
    );

    assign m_axis_tdata = {2'b00, w_out_col, w_out_row, w_out_value};

endmodule

`default_nettype wire

/* design/mrcs_dp.sv */
`timescale 1ns / 1ps
`default_nettype none

module mrcs_dp #(
    parameter int MAX_ROWS = 8,
    parameter int MAX_COLS = 8,
    localparam int LANES  = (MAX_ROWS > MAX_COLS) ? MAX_ROWS : MAX_COLS,
    localparam int DIM_W  = $clog2(LANES + 1),
    localparam int LANE_W = (LANES > 1) ? $clog2(LANES) : 1,
    localparam int DEPTH  = MAX_ROWS * MAX_COLS,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     i_dir,
    input  wire logic [DIM_W-1:0]         i_cols,
    input  wire mrcs_pkg::t_dp_cmd        i_cmd,
    output mrcs_pkg::t_dp_status          o_status,
    input  wire logic [LANE_W-1:0]        i_idx,
    input  wire logic [DIM_W-1:0]         i_len,
    input  wire logic [DIM_W-1:0]         i_row,
    input  wire logic [DIM_W-1:0]         i_col,
    input  wire logic                     i_last,
    input  wire logic signed [31:0]       i_in_value,
    output logic signed [31:0]            o_out_value,
    output logic [2:0]                    o_out_row,
    output logic [2:0]                    o_out_col,
    output logic                          o_out_last,
    output logic                          o_out_valid,
    input  wire logic                     i_out_ready
);
    import mrcs_pkg::*;

    logic signed [DATA_W-1:0] r_mem [DEPTH];
    logic signed [DATA_W-1:0] r_buf [LANES];
    logic signed [DATA_W-1:0] n_buf [LANES];
    logic signed [DATA_W-1:0] r_rdata;
    logic signed [DATA_W-1:0] w_wdata;
    logic [ADDR_W-1:0]        r_addr, n_addr;
    logic [ADDR_W-1:0]        r_base, n_base;
    logic [ADDR_W-1:0]        w_stride, w_bstep;
    logic                     r_fetch_v;
    logic [LANE_W-1:0]        r_fetch_lane;
    logic                     r_out_valid;
    logic signed [DATA_W-1:0] r_out_value;
    logic [2:0]               r_out_row, r_out_col;
    logic                     r_out_last;
    logic                     w_we;

    assign w_stride = i_dir ? ADDR_W'(1) : ADDR_W'(i_cols);
    assign w_bstep  = i_dir ? ADDR_W'(i_cols) : ADDR_W'(1);

    always_comb begin
        n_addr = r_addr;
        n_base = r_base;
        if (i_cmd.line_first) begin
            n_base = '0;
            n_addr = '0;
        end else if (i_cmd.line_next) begin
            n_base = r_base + w_bstep;
            n_addr = r_base + w_bstep;
        end else if (i_cmd.line_rewind) begin
            n_addr = r_base;
        end else if (i_cmd.addr_clr) begin
            n_addr = '0;
        end else if (i_cmd.fetch_rd || i_cmd.wb_wr) begin
            n_addr = r_addr + w_stride;
        end else if (i_cmd.mem_wr_in || i_cmd.emit_rd) begin
            n_addr = r_addr + ADDR_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_addr <= '0;
            r_base <= '0;
        end else begin
            r_addr <= n_addr;
            r_base <= n_base;
        end
    end

    // single-port store, one address shared by writes and reads
    assign w_we    = i_cmd.mem_wr_in || i_cmd.wb_wr;
    assign w_wdata = i_cmd.wb_wr ? r_buf[i_idx] : i_in_value;

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[r_addr] <= w_wdata;
        end
        if (i_cmd.fetch_rd) begin
            r_rdata <= r_mem[r_addr];
        end
        if (i_cmd.emit_rd) begin
            r_out_value <= r_mem[r_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fetch_v <= 1'b0;
        end else begin
            r_fetch_v <= i_cmd.fetch_rd;
        end
        if (i_cmd.fetch_rd) begin
            r_fetch_lane <= i_idx;
        end
    end

    // odd-even transposition step over the line buffer
    always_comb begin
        for (int j = 0; j < LANES; j++) begin
            n_buf[j] = r_buf[j];
        end
        for (int j = 0; j < LANES - 1; j++) begin
            if ((1'(j % 2) == i_cmd.sort_odd) && (j + 1 < int'(i_len))
                    && (r_buf[j] > r_buf[j+1])) begin
                n_buf[j]   = r_buf[j+1];
                n_buf[j+1] = r_buf[j];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_fetch_v) begin
            r_buf[r_fetch_lane] <= r_rdata;
        end else if (i_cmd.sort_en) begin
            for (int j = 0; j < LANES; j++) begin
                r_buf[j] <= n_buf[j];
            end
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit_rd) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
        if (i_cmd.emit_rd) begin
            r_out_row  <= 3'(i_row);
            r_out_col  <= 3'(i_col);
            r_out_last <= i_last;
        end
    end

    assign o_status.out_free = !r_out_valid || i_out_ready;
    assign o_out_valid       = r_out_valid;
    assign o_out_value       = r_out_value;
    assign o_out_row         = r_out_row;
    assign o_out_col         = r_out_col;
    assign o_out_last        = r_out_last;

endmodule

`default_nettype wire

/* design/mrcs_ctrl.sv */
`timescale 1ns / 1ps
`default_nettype none
`include "matrix_row_column_sorter_core_defines.svh"

module mrcs_ctrl #(
    parameter int MAX_ROWS = 8,
    parameter int MAX_COLS = 8,
    localparam int LANES  = (MAX_ROWS > MAX_COLS) ? MAX_ROWS : MAX_COLS,
    localparam int DIM_W  = $clog2(LANES + 1),
    localparam int LANE_W = (LANES > 1) ? $clog2(LANES) : 1,
    localparam int DEPTH  = MAX_ROWS * MAX_COLS,
    localparam int CNT_W  = $clog2(DEPTH + 1)
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_dir,
    input  wire logic [DIM_W-1:0]     i_rows,
    input  wire logic [DIM_W-1:0]     i_cols,
    input  wire logic                 i_s_tvalid,
    output logic                      o_s_tready,
    output mrcs_pkg::t_dp_cmd         o_cmd,
    input  wire mrcs_pkg::t_dp_status i_status,
    output logic [LANE_W-1:0]         o_idx,
    output logic [DIM_W-1:0]          o_len,
    output logic [DIM_W-1:0]          o_row,
    output logic [DIM_W-1:0]          o_col,
    output logic                      o_last
);
    import mrcs_pkg::*;

    localparam logic [2:0] S_LOAD  = 3'd0;
    localparam logic [2:0] S_FETCH = 3'd1;
    localparam logic [2:0] S_SORT  = 3'd2;
    localparam logic [2:0] S_WB    = 3'd3;
    localparam logic [2:0] S_EMIT  = 3'd4;

    logic [2:0]       r_state, n_state;
    logic [CNT_W-1:0] r_load_cnt, n_load_cnt;
    logic [DIM_W-1:0] r_idx, n_idx;
    logic [DIM_W-1:0] r_phase, n_phase;
    logic [DIM_W-1:0] r_line, n_line;
    logic [DIM_W-1:0] r_row, n_row;
    logic [DIM_W-1:0] r_col, n_col;
    logic [DIM_W-1:0] w_len, w_lines;
    logic [CNT_W-1:0] w_total, w_cnt_inc;
    logic             w_last, w_load_done;

    assign w_len       = i_dir ? i_cols : i_rows;
    assign w_lines     = i_dir ? i_rows : i_cols;
    assign w_total     = CNT_W'(i_rows) * CNT_W'(i_cols);
    assign w_cnt_inc   = r_load_cnt + CNT_W'(1);
    assign w_last      = (r_row == i_rows - DIM_W'(1)) && (r_col == i_cols - DIM_W'(1));
    assign w_load_done = (r_state == S_LOAD) && i_s_tvalid && (w_cnt_inc >= w_total);

    always_comb begin
        n_state    = r_state;
        n_load_cnt = r_load_cnt;
        n_idx      = r_idx;
        n_phase    = r_phase;
        n_line     = r_line;
        n_row      = r_row;
        n_col      = r_col;
        o_cmd      = '0;
        o_s_tready = 1'b0;
        unique case (r_state)
            S_LOAD: begin
                o_s_tready = 1'b1;
                if (i_s_tvalid) begin
                    o_cmd.mem_wr_in = 1'b1;
                    if (w_cnt_inc >= w_total) begin
                        n_load_cnt       = '0;
                        o_cmd.line_first = 1'b1;
                        n_idx            = '0;
                        n_line           = '0;
                        n_state          = S_FETCH;
                    end else begin
                        n_load_cnt = w_cnt_inc;
                    end
                end
            end
            S_FETCH: begin
                if (r_idx < w_len) begin
                    o_cmd.fetch_rd = 1'b1;
                    n_idx          = r_idx + DIM_W'(1);
                end else begin
                    n_phase = '0;
                    n_state = S_SORT;
                end
            end
            S_SORT: begin
                o_cmd.sort_en  = 1'b1;
                o_cmd.sort_odd = r_phase[0];
                n_phase        = r_phase + DIM_W'(1);
                if (r_phase == w_len - DIM_W'(1)) begin
                    n_idx             = '0;
                    o_cmd.line_rewind = 1'b1;
                    n_state           = S_WB;
                end
            end
            S_WB: begin
                o_cmd.wb_wr = 1'b1;
                n_idx       = r_idx + DIM_W'(1);
                if (r_idx == w_len - DIM_W'(1)) begin
                    if (r_line == w_lines - DIM_W'(1)) begin
                        o_cmd.addr_clr = 1'b1;
                        n_row          = '0;
                        n_col          = '0;
                        n_state        = S_EMIT;
                    end else begin
                        o_cmd.line_next = 1'b1;
                        n_line          = r_line + DIM_W'(1);
                        n_idx           = '0;
                        n_state         = S_FETCH;
                    end
                end
            end
            S_EMIT: begin
                if (i_status.out_free) begin
                    o_cmd.emit_rd = 1'b1;
                    if (w_last) begin
                        // next matrix loads from the start of the store
                        o_cmd.addr_clr = 1'b1;
                        n_state        = S_LOAD;
                    end else if (r_col == i_cols - DIM_W'(1)) begin
                        n_col = '0;
                        n_row = r_row + DIM_W'(1);
                    end else begin
                        n_col = r_col + DIM_W'(1);
                    end
                end
            end
            default: begin
                n_state = S_LOAD;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_LOAD;
            r_load_cnt <= '0;
            r_idx      <= '0;
            r_phase    <= '0;
            r_line     <= '0;
            r_row      <= '0;
            r_col      <= '0;
        end else begin
            r_state    <= n_state;
            r_load_cnt <= n_load_cnt;
            r_idx      <= n_idx;
            r_phase    <= n_phase;
            r_line     <= n_line;
            r_row      <= n_row;
            r_col      <= n_col;
        end
    end

    assign o_idx  = r_idx[LANE_W-1:0];
    assign o_len  = w_len;
    assign o_row  = r_row;
    assign o_col  = r_col;
    assign o_last = w_last;

    `MRCS_ASSERT_IMP(a_emit_slot_free, o_cmd.emit_rd, i_status.out_free,
        "emit read with output slot busy")
    `MRCS_ASSERT_NXT(a_load_done_sort, w_load_done,
        (r_state == S_FETCH) && (r_load_cnt == '0), "full matrix did not start sorting")
    `MRCS_ASSERT_NXT(a_emit_end_load, o_cmd.emit_rd && w_last, r_state == S_LOAD,
        "last element did not return to loading")
    `MRCS_ASSERT_IMP(a_phase_range, r_state == S_SORT, r_phase < w_len,
        "sort phase beyond line length")

endmodule

`default_nettype wire

/* bench/matrix_row_column_sorter_core_tb.sv */
`timescale 1ns / 1ps

module matrix_row_column_sorter_core_tb;
    import mrcs_pkg::*;

    localparam int MAX_ROWS     = 8;
    localparam int MAX_COLS     = 8;
    localparam int STORE_DEPTH  = MAX_ROWS * MAX_COLS;
    localparam int RESET_CYCLES = 4;
    localparam int SETTLE_CYCLES = 12;
    localparam int TAIL_CYCLES  = 60;
    localparam int HOLD_CYCLES  = 600;
    localparam int ITEM_TARGET  = 380;
    localparam logic [1:0] REG_UNUSED = 2'd3;

    typedef struct {
        logic signed [31:0] value;
        logic [2:0]         row;
        logic [2:0]         col;
        logic               last;
    } sorted_elem_t;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [3:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata = '0;  // [31:0] elem_value
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [39:0] m_axis_tdata;  // [31:0] out_value, [34:32] out_row, [37:35] out_col
    logic        m_axis_tlast;

    logic [31:0]  elem_q[$];
    sorted_elem_t sorted_q[$];
    int unsigned  err_cnt = 0;
    int unsigned  send_idle_pct = 16;
    int unsigned  recv_idle_pct = 82;
    int unsigned  hold_left = 0;
    logic         hold_go = 1'b0;

    // predictor state
    logic signed [31:0] elem_store[STORE_DEPTH];
    int unsigned        load_cnt = 0;
    logic               cfg_dir = 1'b0;
    logic [3:0]         cfg_rows = 4'd8;
    logic [3:0]         cfg_cols = 4'd5;

    matrix_row_column_sorter_core #(
        .MAX_ROWS(MAX_ROWS),
        .MAX_COLS(MAX_COLS)
    ) i_dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .psel(psel),
        .penable(penable),
        .pwrite(pwrite),
        .paddr(paddr),
        .pwdata(pwdata),
        .prdata(prdata),
        .pready(pready),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .m_axis_tlast(m_axis_tlast)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #(5_000_000);
        $display("matrix_row_column_sorter_core regression: fail");
        $finish;
    end

    function automatic int unsigned eff_dim(input logic [3:0] d, input int unsigned maxv);
        if (d == 4'd0) begin
            return 1;
        end
        return (d > maxv) ? maxv : d;
    endfunction

    // store one element; on the last one of the matrix sort it and queue all results
    function automatic void load_and_sort(input logic [31:0] v);
        int unsigned rows, cols, total, nlines, n, stride, base, i, j, k;
        logic signed [31:0] key;
        sorted_elem_t e;
        rows = eff_dim(cfg_rows, MAX_ROWS);
        cols = eff_dim(cfg_cols, MAX_COLS);
        total = rows * cols;
        if (load_cnt < STORE_DEPTH) begin
            elem_store[load_cnt] = v;
        end
        load_cnt++;
        if (load_cnt < total) begin
            return;
        end
        nlines = cfg_dir ? rows : cols;
        n      = cfg_dir ? cols : rows;
        stride = cfg_dir ? 1 : cols;
        for (int ln = 0; ln < nlines; ln++) begin
            base = cfg_dir ? ln * cols : ln;
            for (i = 1; i < n; i++) begin
                key = elem_store[base + i * stride];
                j = i;
                while (j > 0 && elem_store[base + (j - 1) * stride] > key) begin
                    elem_store[base + j * stride] = elem_store[base + (j - 1) * stride];
                    j--;
                end
                elem_store[base + j * stride] = key;
            end
        end
        for (k = 0; k < total; k++) begin
            e.value = elem_store[k];
            e.row   = 3'(k / cols);
            e.col   = 3'(k % cols);
            e.last  = (k + 1 == total);
            sorted_q.push_back(e);
        end
        load_cnt = 0;
    endfunction

    // request driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                load_and_sort(s_axis_tdata);
            end
            if (!s_axis_tvalid || s_axis_tready) begin
                if (elem_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    s_axis_tdata  <= elem_q.pop_front();
                    s_axis_tvalid <= 1'b1;
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // long sink hold-off
    always @(posedge i_clk) begin
        if (hold_go && hold_left == 0) begin
            hold_left <= HOLD_CYCLES;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end
    end

    // result monitor
    always @(posedge i_clk) begin
        sorted_elem_t e;
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                if (sorted_q.size() == 0) begin
                    $display("%0t: unexpected result, got value %h row %0d col %0d last %b",
                             $time, m_axis_tdata[31:0], m_axis_tdata[34:32],
                             m_axis_tdata[37:35], m_axis_tlast);
                    err_cnt++;
                end else begin
                    e = sorted_q.pop_front();
                    if (m_axis_tdata[31:0] !== e.value) begin
                        $display("%0t: value mismatch, expected %h, got %h",
                                 $time, e.value, m_axis_tdata[31:0]);
                        err_cnt++;
                    end
                    if (m_axis_tdata[34:32] !== e.row) begin
                        $display("%0t: row mismatch, expected %0d, got %0d",
                                 $time, e.row, m_axis_tdata[34:32]);
                        err_cnt++;
                    end
                    if (m_axis_tdata[37:35] !== e.col) begin
                        $display("%0t: col mismatch, expected %0d, got %0d",
                                 $time, e.col, m_axis_tdata[37:35]);
                        err_cnt++;
                    end
                    if (m_axis_tlast !== e.last) begin
                        $display("%0t: last mismatch, expected %b, got %b",
                                 $time, e.last, m_axis_tlast);
                        err_cnt++;
                    end
                    if (m_axis_tdata[39:38] !== 2'b00) begin
                        $display("%0t: padding mismatch, expected 0, got %b",
                                 $time, m_axis_tdata[39:38]);
                        err_cnt++;
                    end
                end
            end
            m_axis_tready <= (hold_left == 0) && ($urandom_range(99) >= recv_idle_pct);
        end
    end

    task automatic reg_write(input logic [1:0] idx, input logic [31:0] val);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // upper data bits are random, only the field bits count
    task automatic set_shape(input logic dir, input logic [3:0] rows, input logic [3:0] cols);
        logic [31:0] noise;
        noise = $urandom();
        reg_write(REG_SORT_DIRECTION, {noise[31:1], dir});
        noise = $urandom();
        reg_write(REG_NUM_ROWS, {noise[31:4], rows});
        noise = $urandom();
        reg_write(REG_NUM_COLS, {noise[31:4], cols});
        cfg_dir  = dir;
        cfg_rows = rows;
        cfg_cols = cols;
    endtask

    task automatic wait_drained();
        do @(negedge i_clk);
        while (elem_q.size() != 0 || s_axis_tvalid || sorted_q.size() != 0);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    function automatic logic [31:0] pick_elem();
        int v;
        case ($urandom_range(3))
            0: begin
                case ($urandom_range(5))
                    0: return 32'h8000_0000;
                    1: return 32'h7fff_ffff;
                    2: return 32'h0000_0000;
                    3: return 32'hffff_ffff;
                    4: return 32'h8000_0001;
                    default: return 32'h7fff_fffe;
                endcase
            end
            1: begin
                v = $urandom_range(8);
                return 32'(v - 4);
            end
            default: return $urandom();
        endcase
    endfunction

    initial begin : stimulus
        int unsigned items_sent, ph, nmat, dims;
        logic        d;
        logic [3:0]  r, c;
        items_sent = 0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // reset shape: 8 x 5 by column
        repeat (40) elem_q.push_back(pick_elem());
        items_sent += 40;
        wait_drained();

        // extremes by column
        set_shape(1'b0, 4'd3, 4'd2);
        reg_write(REG_UNUSED, $urandom());
        elem_q.push_back(32'h7fff_ffff);
        elem_q.push_back(32'h8000_0000);
        elem_q.push_back(32'h0000_0000);
        elem_q.push_back(32'hffff_ffff);
        elem_q.push_back(32'h8000_0000);
        elem_q.push_back(32'h7fff_ffff);
        wait_drained();

        // ties by row
        set_shape(1'b1, 4'd2, 4'd4);
        elem_q.push_back(32'd5);
        elem_q.push_back(32'd5);
        elem_q.push_back(32'hffff_ffff);
        elem_q.push_back(32'h8000_0000);
        elem_q.push_back(32'h7fff_ffff);
        elem_q.push_back(32'd0);
        elem_q.push_back(32'h7fff_ffff);
        elem_q.push_back(32'd1);
        wait_drained();

        // zero dimensions act as one
        set_shape(1'b1, 4'd0, 4'd0);
        elem_q.push_back(32'h8000_0000);
        elem_q.push_back(32'h7fff_ffff);
        wait_drained();

        // oversized rows act as the maximum, reversed column
        set_shape(1'b0, 4'd15, 4'd1);
        elem_q.push_back(32'h7fff_ffff);
        elem_q.push_back(32'h4000_0000);
        elem_q.push_back(32'h0000_0001);
        elem_q.push_back(32'h0000_0000);
        elem_q.push_back(32'hffff_ffff);
        elem_q.push_back(32'hc000_0000);
        elem_q.push_back(32'h8000_0001);
        elem_q.push_back(32'h8000_0000);
        items_sent += 24;
        wait_drained();

        ph = 0;
        while (items_sent < ITEM_TARGET) begin
            if (items_sent >= 2 * ITEM_TARGET / 3) begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end else if (items_sent >= ITEM_TARGET / 3) begin
                send_idle_pct = 82;
                recv_idle_pct = 16;
            end
            if (ph == 0) begin
                d = 1'b1;
                r = 4'd8;
                c = 4'd8;
            end else if (ph == 1) begin
                d = 1'b0;
                r = 4'd1;
                c = 4'd8;
            end else begin
                d = 1'($urandom_range(1));
                r = 4'($urandom_range(15));
                c = 4'($urandom_range(15));
            end
            set_shape(d, r, c);
            dims = eff_dim(r, MAX_ROWS) * eff_dim(c, MAX_COLS);
            nmat = 48 / dims;
            if (nmat == 0) begin
                nmat = (ph == 0) ? 2 : 1;
            end else if (nmat > 6) begin
                nmat = 6;
            end
            for (int m = 0; m < nmat; m++) begin
                // sender pause until the sorter has drained
                if (m != 0 && (ph == 1 || (ph != 0 && $urandom_range(3) == 0))) begin
                    wait_drained();
                end
                repeat (dims) elem_q.push_back(pick_elem());
                items_sent += dims;
                if (ph == 0 && m == 1) begin
                    hold_go = 1'b1;
                    @(negedge i_clk);
                    hold_go = 1'b0;
                end
            end
            wait_drained();
            ph++;
        end

        repeat (TAIL_CYCLES) @(negedge i_clk);
        if (err_cnt == 0) begin
            $display("matrix_row_column_sorter_core regression: pass");
        end else begin
            $display("matrix_row_column_sorter_core regression: fail");
        end
        $finish;
    end

endmodule
